### hdl/spq_pkg.sv
package spq_pkg;

	// Defaults for the top-level parameters.
	localparam int DEF_CAPACITY      = 16;
	localparam int DEF_PRIORITY_BITS = 16;

	// Fixed widths of the transaction fields.
	localparam int PRI_FIELD_BITS = 16;
	localparam int VALUE_BITS     = 32;
	localparam int OCC_BITS       = 5;

	// Operation codes carried by the op field.
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// Controller states: no result held, or a result waiting to be taken.
	typedef enum logic {
		ST_IDLE,
		ST_HOLD
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic push;   // insert the new entry
		logic pop;    // remove the head entry
		logic load;   // capture the result of the accepted transaction
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic empty;
	} dp_status_t;

endpackage

### hdl/spq_ctrl.sv
module spq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  logic                op,
	output logic                result_valid,
	input  logic                result_ready,
	input  spq_pkg::dp_status_t status,
	output spq_pkg::dp_cmd_t    cmd
);

	spq_pkg::ctrl_state_t state_q;
	spq_pkg::ctrl_state_t state_nxt;
	logic                 accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// A new transaction may enter as the held result leaves.
	assign item_ready = (state_q == spq_pkg::ST_IDLE) || result_ready;
	assign accept     = item_valid && item_ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			spq_pkg::ST_IDLE: begin
				if (accept) state_nxt = spq_pkg::ST_HOLD;
			end
			spq_pkg::ST_HOLD: begin
				if (accept) state_nxt = spq_pkg::ST_HOLD;
				else if (result_ready) state_nxt = spq_pkg::ST_IDLE;
			end
			default: state_nxt = spq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		result_valid = 1'b0;
		cmd.push     = 1'b0;
		cmd.pop      = 1'b0;
		cmd.load     = 1'b0;
		case (state_q)
			spq_pkg::ST_IDLE: begin
				result_valid = 1'b0;
			end
			spq_pkg::ST_HOLD: begin
				result_valid = 1'b1;
			end
			default: result_valid = 1'b0;
		endcase
		if (accept) begin
			cmd.load = 1'b1;
			cmd.push = (op == spq_pkg::OP_PUSH) && !status.full;
			cmd.pop  = (op == spq_pkg::OP_POP) && !status.empty;
		end
	end

endmodule

### hdl/spq_datapath.sv
module spq_datapath #(
	parameter int CAPACITY      = spq_pkg::DEF_CAPACITY,
	parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  spq_pkg::dp_cmd_t                          cmd,
	output spq_pkg::dp_status_t                       status,
	input  logic                                      op,
	input  logic        [spq_pkg::PRI_FIELD_BITS-1:0] push_priority,
	input  logic signed [spq_pkg::VALUE_BITS-1:0]     push_value,
	output logic                                      pop_valid,
	output logic        [spq_pkg::PRI_FIELD_BITS-1:0] pop_priority,
	output logic signed [spq_pkg::VALUE_BITS-1:0]     pop_value,
	output logic                                      was_empty,
	output logic                                      push_dropped,
	output logic        [spq_pkg::OCC_BITS-1:0]       occupancy
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [PRIORITY_BITS-1:0]       prio_q [CAPACITY];
	logic [spq_pkg::VALUE_BITS-1:0] val_q  [CAPACITY];
	logic [CW-1:0]                  count_q;
	logic [CW-1:0]                  count_nxt;
	logic [PRIORITY_BITS-1:0]       pri_in;
	logic [spq_pkg::PRI_FIELD_BITS-1:0] head_pri;
	logic [spq_pkg::OCC_BITS-1:0]   occ_nxt;
	logic [CAPACITY-1:0]            after;

	logic                                pop_valid_q;
	logic [spq_pkg::PRI_FIELD_BITS-1:0]  pop_priority_q;
	logic [spq_pkg::VALUE_BITS-1:0]      pop_value_q;
	logic                                was_empty_q;
	logic                                push_dropped_q;
	logic [spq_pkg::OCC_BITS-1:0]        occupancy_q;

	generate
		if (PRIORITY_BITS <= spq_pkg::PRI_FIELD_BITS) begin : g_pri_narrow
			assign pri_in   = push_priority[PRIORITY_BITS-1:0];
			assign head_pri = spq_pkg::PRI_FIELD_BITS'(prio_q[0]);
		end else begin : g_pri_wide
			assign pri_in   = {{(PRIORITY_BITS-spq_pkg::PRI_FIELD_BITS){1'b0}}, push_priority};
			assign head_pri = prio_q[0][spq_pkg::PRI_FIELD_BITS-1:0];
		end
		if (CW >= spq_pkg::OCC_BITS) begin : g_occ_trim
			assign occ_nxt = count_nxt[spq_pkg::OCC_BITS-1:0];
		end else begin : g_occ_ext
			assign occ_nxt = {{(spq_pkg::OCC_BITS-CW){1'b0}}, count_nxt};
		end
	endgenerate

	assign status.full  = (count_q == CW'(CAPACITY));
	assign status.empty = (count_q == '0);

	// Each cell decides on its own whether the new entry belongs at or before it.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			after[i] = (CW'(i) >= count_q) || (pri_in <= prio_q[i]);
		end
	end

	always_comb begin
		count_nxt = count_q;
		if (cmd.push) count_nxt = count_q + CW'(1);
		else if (cmd.pop) count_nxt = count_q - CW'(1);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (cmd.push) begin
				if (i > 0 && after[(i > 0) ? i - 1 : 0]) begin
					prio_q[i] <= prio_q[(i > 0) ? i - 1 : 0];
					val_q[i]  <= val_q[(i > 0) ? i - 1 : 0];
				end else if (after[i]) begin
					prio_q[i] <= pri_in;
					val_q[i]  <= push_value;
				end
			end else if (cmd.pop && i < CAPACITY - 1) begin
				prio_q[i] <= prio_q[(i < CAPACITY - 1) ? i + 1 : i];
				val_q[i]  <= val_q[(i < CAPACITY - 1) ? i + 1 : i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pop_valid_q    <= cmd.pop;
			pop_priority_q <= cmd.pop ? head_pri : '0;
			pop_value_q    <= cmd.pop ? val_q[0] : '0;
			was_empty_q    <= (op == spq_pkg::OP_POP) && status.empty;
			push_dropped_q <= (op == spq_pkg::OP_PUSH) && status.full;
			occupancy_q    <= occ_nxt;
		end
	end

	assign pop_valid    = pop_valid_q;
	assign pop_priority = pop_priority_q;
	assign pop_value    = pop_value_q;
	assign was_empty    = was_empty_q;
	assign push_dropped = push_dropped_q;
	assign occupancy    = occupancy_q;

endmodule

### hdl/sorted_priority_queue.sv
// Sorted-list priority queue: the result of an accepted transaction appears in the next cycle.
// Throughput is one transaction per cycle; the only limit is the single result register,
// which frees up in the same cycle that its result is taken.
// The entry store is a shift line of CAPACITY cells; insertion and removal shift it in place.
// Reset (arst_n, asynchronous, active low) empties the queue and drops any held result;
// stored entries are not cleared, as only entries below the count are ever read.
module sorted_priority_queue #(
	parameter int CAPACITY      = spq_pkg::DEF_CAPACITY,
	parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      item_valid,
	output logic                                      item_ready,
	input  logic                                      op,
	input  logic        [spq_pkg::PRI_FIELD_BITS-1:0] push_priority,
	input  logic signed [spq_pkg::VALUE_BITS-1:0]     push_value,
	output logic                                      result_valid,
	input  logic                                      result_ready,
	output logic                                      pop_valid,
	output logic        [spq_pkg::PRI_FIELD_BITS-1:0] pop_priority,
	output logic signed [spq_pkg::VALUE_BITS-1:0]     pop_value,
	output logic                                      was_empty,
	output logic                                      push_dropped,
	output logic        [spq_pkg::OCC_BITS-1:0]       occupancy
);

	// The controller runs the handshakes and turns each accepted transaction into
	// push, pop and capture commands. It never pushes into a full queue nor pops an
	// empty one; those cases only flag the result.
	spq_pkg::dp_cmd_t    cmd;
	spq_pkg::dp_status_t status;

	spq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.op           (op),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.cmd          (cmd)
	);

	// The datapath holds the sorted cells with the head at cell zero. On a push every
	// cell compares the new priority with its own in parallel; cells from the insertion
	// point onwards shift one place towards the tail. A pop shifts every cell one place
	// towards the head. The result register sits at the output of this module.
	spq_datapath #(
		.CAPACITY      (CAPACITY),
		.PRIORITY_BITS (PRIORITY_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.op            (op),
		.push_priority (push_priority),
		.push_value    (push_value),
		.pop_valid     (pop_valid),
		.pop_priority  (pop_priority),
		.pop_value     (pop_value),
		.was_empty     (was_empty),
		.push_dropped  (push_dropped),
		.occupancy     (occupancy)
	);

endmodule

### hdl/spq_checker.sv
module spq_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                item_valid,
	input logic                                item_ready,
	input logic                                result_valid,
	input logic                                result_ready,
	input logic                                pop_valid,
	input logic                                was_empty,
	input logic                                push_dropped,
	input logic [spq_pkg::OCC_BITS-1:0]        occupancy
);

	// A held result stays until it is taken.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result withdrawn before it was taken");

	// An accepted transaction always yields a result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> result_valid)
		else $error("accepted transaction produced no result");

	// At most one outcome flag per result.
	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $countones({pop_valid, was_empty, push_dropped}) <= 1)
		else $error("result carries conflicting outcome flags");

	// A pop that found the queue empty leaves it empty.
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && was_empty |-> occupancy == '0)
		else $error("empty pop reported non-zero occupancy");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.pop_valid    (pop_valid),
	.was_empty    (was_empty),
	.push_dropped (push_dropped),
	.occupancy    (occupancy)
);

### test/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the sorted-list priority queue.
// An initial block fills a queue of pending transactions, a clocked driver presents them on the
// item channel and a clocked monitor predicts every accepted item and checks every result.
module testbench;

	localparam int CAPACITY       = 16;
	localparam int PRIO_BITS      = 16;
	localparam int RANDOM_ITEMS   = 1450;
	localparam int PHASE_LENGTH   = 120;
	localparam int TAIL_CYCLES    = 8;
	localparam int WATCHDOG_LIMIT = 5000;

	// Bits of the priority field that the queue keeps.
	localparam logic [spq_pkg::PRI_FIELD_BITS-1:0] PRI_KEEP =
		(PRIO_BITS >= spq_pkg::PRI_FIELD_BITS) ? '1 :
		spq_pkg::PRI_FIELD_BITS'((1 << PRIO_BITS) - 1);

	// How the two channels idle while a transaction is in flight.
	typedef enum logic [1:0] {
		PH_FREE,
		PH_SEND_IDLE,
		PH_RECV_STALL,
		PH_BOTH
	} idle_phase_t;

	typedef struct packed {
		logic                               op;
		logic [spq_pkg::PRI_FIELD_BITS-1:0] pri;
		logic [spq_pkg::VALUE_BITS-1:0]     val;
		idle_phase_t                        phase;
	} queued_item_t;

	typedef struct packed {
		logic                               pop_valid;
		logic [spq_pkg::PRI_FIELD_BITS-1:0] pop_priority;
		logic [spq_pkg::VALUE_BITS-1:0]     pop_value;
		logic                               was_empty;
		logic                               push_dropped;
		logic [spq_pkg::OCC_BITS-1:0]       occupancy;
	} queue_result_t;

	logic                                      clk;
	logic                                      arst_n;
	logic                                      item_valid;
	logic                                      item_ready;
	logic                                      op;
	logic        [spq_pkg::PRI_FIELD_BITS-1:0] push_priority;
	logic signed [spq_pkg::VALUE_BITS-1:0]     push_value;
	logic                                      result_valid;
	logic                                      result_ready;
	logic                                      pop_valid;
	logic        [spq_pkg::PRI_FIELD_BITS-1:0] pop_priority;
	logic signed [spq_pkg::VALUE_BITS-1:0]     pop_value;
	logic                                      was_empty;
	logic                                      push_dropped;
	logic        [spq_pkg::OCC_BITS-1:0]       occupancy;

	// Transactions waiting to be driven, and results waiting to be seen.
	queued_item_t  pending_items[$];
	queue_result_t awaited_results[$];

	// The bench's own copy of the queue contents, head at index 0.
	logic [spq_pkg::PRI_FIELD_BITS-1:0] held_priorities[CAPACITY];
	logic [spq_pkg::VALUE_BITS-1:0]     held_values[CAPACITY];
	int                                 held_count;

	idle_phase_t cur_phase;
	logic        item_taken;
	int          items_total;
	int          items_accepted;
	int          mismatches;
	int          quiet_cycles;

	sorted_priority_queue #(
		.CAPACITY      (CAPACITY),
		.PRIORITY_BITS (PRIO_BITS)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.op            (op),
		.push_priority (push_priority),
		.push_value    (push_value),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.pop_valid     (pop_valid),
		.pop_priority  (pop_priority),
		.pop_value     (pop_value),
		.was_empty     (was_empty),
		.push_dropped  (push_dropped),
		.occupancy     (occupancy)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Applies one transaction to the bench's copy of the queue and returns the result it
	// should produce. A push slots in ahead of the first entry of equal or greater priority,
	// so the newest of several equal priorities is served first.
	function automatic queue_result_t next_queue_result(input logic op_in,
			input logic [spq_pkg::PRI_FIELD_BITS-1:0] pri_in,
			input logic [spq_pkg::VALUE_BITS-1:0] val_in);
		queue_result_t                      res;
		logic [spq_pkg::PRI_FIELD_BITS-1:0] pri;
		int                                 pos;
		res = '0;
		pri = pri_in & PRI_KEEP;
		if (op_in == spq_pkg::OP_PUSH) begin
			if (held_count >= CAPACITY) begin
				res.push_dropped = 1'b1;
			end else begin
				pos = held_count;
				for (int i = held_count - 1; i >= 0; i--) begin
					if (pri <= held_priorities[i])
						pos = i;
				end
				for (int i = held_count; i > pos; i--) begin
					held_priorities[i] = held_priorities[i-1];
					held_values[i]     = held_values[i-1];
				end
				held_priorities[pos] = pri;
				held_values[pos]     = val_in;
				held_count++;
			end
		end else if (held_count == 0) begin
			res.was_empty = 1'b1;
		end else begin
			res.pop_valid    = 1'b1;
			res.pop_priority = held_priorities[0];
			res.pop_value    = held_values[0];
			for (int i = 1; i < held_count; i++) begin
				held_priorities[i-1] = held_priorities[i];
				held_values[i-1]     = held_values[i];
			end
			held_count--;
		end
		res.occupancy = spq_pkg::OCC_BITS'(held_count);
		return res;
	endfunction

	task automatic flag_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] mismatch on %s: got %h, expected %h", $time, field, got, want);
		mismatches++;
	endtask

	task automatic queue_item(input logic op_in,
			input logic [spq_pkg::PRI_FIELD_BITS-1:0] pri_in,
			input logic [spq_pkg::VALUE_BITS-1:0] val_in, input idle_phase_t phase_in);
		queued_item_t item;
		item.op    = op_in;
		item.pri   = pri_in;
		item.val   = val_in;
		item.phase = phase_in;
		pending_items.push_back(item);
		items_total++;
	endtask

	// Picks a priority: often uniform, often from a tiny range so that ties are common,
	// now and then one of the two extremes, and now and then one just around the midpoint.
	function automatic logic [spq_pkg::PRI_FIELD_BITS-1:0] pick_priority();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel <= 3)
			return spq_pkg::PRI_FIELD_BITS'($urandom);
		else if (sel <= 6)
			return spq_pkg::PRI_FIELD_BITS'($urandom_range(0, 3));
		else if (sel == 7)
			return '0;
		else if (sel == 8)
			return '1;
		else
			return spq_pkg::PRI_FIELD_BITS'(16'h8000 + $urandom_range(0, 4) - 2);
	endfunction

	function automatic logic [spq_pkg::VALUE_BITS-1:0] pick_value();
		int sel;
		sel = $urandom_range(0, 15);
		if (sel == 0)
			return 32'h8000_0000;
		else if (sel == 1)
			return 32'h7fff_ffff;
		else if (sel == 2)
			return 32'hffff_ffff;
		else
			return $urandom;
	endfunction

	// Driver: presents a new transaction at the falling edge once the previous one has been
	// accepted, or idles when the phase of the next transaction asks for a gap. The phase of
	// the transaction on the bus also decides how often the result side stalls.
	always @(negedge clk) begin
		int          gap_pct;
		int          stall_pct;
		idle_phase_t next_phase;
		queued_item_t item;
		if (arst_n) begin
			if (!item_valid || item_taken) begin
				next_phase = (pending_items.size() != 0) ? pending_items[0].phase : PH_FREE;
				gap_pct    = (next_phase == PH_SEND_IDLE) ? 77 :
				             (next_phase == PH_BOTH) ? 27 : 0;
				if (pending_items.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
					item = pending_items.pop_front();
					item_valid    <= 1'b1;
					op            <= item.op;
					push_priority <= item.pri;
					push_value    <= item.val;
					cur_phase     <= item.phase;
				end else begin
					item_valid <= 1'b0;
				end
			end
			stall_pct = (cur_phase == PH_RECV_STALL) ? 77 : (cur_phase == PH_BOTH) ? 27 : 0;
			result_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Monitor: at each rising edge an accepted item is run through the predictor, and an
	// accepted result is compared field by field with the oldest awaited one. A result cannot
	// belong to an item accepted at the same edge, so the order of the two steps is free.
	always @(posedge clk) begin
		queue_result_t want;
		if (!arst_n) begin
			item_taken <= 1'b0;
		end else begin
			item_taken <= item_valid && item_ready;
			if (item_valid && item_ready) begin
				awaited_results.push_back(next_queue_result(op, push_priority, push_value));
				items_accepted++;
			end
			if (result_valid && result_ready) begin
				if (awaited_results.size() == 0) begin
					flag_mismatch("result with none awaited", 32'(occupancy), 32'h0);
				end else begin
					want = awaited_results.pop_front();
					if (pop_valid !== want.pop_valid)
						flag_mismatch("pop_valid", 32'(pop_valid), 32'(want.pop_valid));
					if (pop_priority !== want.pop_priority)
						flag_mismatch("pop_priority", 32'(pop_priority),
							32'(want.pop_priority));
					if (pop_value !== want.pop_value)
						flag_mismatch("pop_value", pop_value, want.pop_value);
					if (was_empty !== want.was_empty)
						flag_mismatch("was_empty", 32'(was_empty), 32'(want.was_empty));
					if (push_dropped !== want.push_dropped)
						flag_mismatch("push_dropped", 32'(push_dropped),
							32'(want.push_dropped));
					if (occupancy !== want.occupancy)
						flag_mismatch("occupancy", 32'(occupancy), 32'(want.occupancy));
				end
			end
		end
	end

	// Watchdog: a long run of cycles with no transaction on either channel means the block
	// has hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("[sorted_priority_queue] ERROR");
				$finish;
			end
		end
	end

	initial begin
		int          burst_len;
		int          push_pct;
		int          made;
		idle_phase_t phase;
		arst_n         = 1'b0;
		item_valid     = 1'b0;
		op             = spq_pkg::OP_PUSH;
		push_priority  = '0;
		push_value     = '0;
		result_ready   = 1'b0;
		cur_phase      = PH_FREE;
		item_taken     = 1'b0;
		items_total    = 0;
		items_accepted = 0;
		mismatches     = 0;
		quiet_cycles   = 0;
		held_count     = 0;

		// Directed part: a pop on the empty queue, the extremes of priority and value, two
		// equal priorities whose newer entry must come out first, a fill to the brim, a
		// push that is dropped because the queue is full, then a few pops from the head.
		queue_item(spq_pkg::OP_POP, 16'h1234, 32'h5555_aaaa, PH_FREE);
		queue_item(spq_pkg::OP_PUSH, 16'hffff, 32'h7fff_ffff, PH_FREE);
		queue_item(spq_pkg::OP_PUSH, 16'h0000, 32'h8000_0000, PH_FREE);
		queue_item(spq_pkg::OP_PUSH, 16'h8000, 32'hffff_ffff, PH_FREE);
		queue_item(spq_pkg::OP_PUSH, 16'h8000, 32'h0000_0001, PH_FREE);
		for (int i = 0; i < CAPACITY - 4; i++)
			queue_item(spq_pkg::OP_PUSH, spq_pkg::PRI_FIELD_BITS'(16'h4000 + (i % 3)),
				$urandom, PH_FREE);
		queue_item(spq_pkg::OP_PUSH, 16'h0000, 32'hdead_beef, PH_FREE);
		for (int i = 0; i < 5; i++)
			queue_item(spq_pkg::OP_POP, 16'hffff, 32'hffff_ffff, PH_FREE);

		// Random part: bursts that lean towards pushes or pops, so the queue swings between
		// full and empty many times. The idling phase changes every 120 items.
		made = 0;
		while (made < RANDOM_ITEMS) begin
			burst_len = $urandom_range(4, 24);
			case ($urandom_range(0, 2))
				0:       push_pct = 85;
				1:       push_pct = 15;
				default: push_pct = 50;
			endcase
			for (int i = 0; i < burst_len; i++) begin
				phase = idle_phase_t'((made / PHASE_LENGTH) % 4);
				queue_item(($urandom_range(0, 99) < push_pct) ? spq_pkg::OP_PUSH :
					spq_pkg::OP_POP, pick_priority(), pick_value(), phase);
				made++;
			end
		end

		// Reset is released with a nonblocking update so that the driver, which also runs
		// on the falling edge, sees it only from the next cycle on.
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		while (items_accepted < items_total || awaited_results.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (mismatches == 0) begin
			$display("[sorted_priority_queue] OK");
		end else begin
			$display("[sorted_priority_queue] ERROR");
		end
		$finish;
	end

endmodule

### sim.f
hdl/spq_pkg.sv
hdl/spq_ctrl.sv
hdl/spq_datapath.sv
hdl/sorted_priority_queue.sv
hdl/spq_checker.sv
test/testbench.sv
